/* sv/aor_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aor_pkg
// Shared constants for the adaptive operator roulette block: default
// parameter values, register indexes and register reset values.
// ----------------------------------------------------------------------------
package aor_pkg;

  localparam int MAX_OPS_DEF    = 4;
  localparam int WEIGHT_FRAC_DEF = 16;
  localparam int COUNT_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic [2:0] REG_OPS_IN_USE   = 3'd0;
  localparam logic [2:0] REG_INIT_W0      = 3'd1;
  localparam logic [2:0] REG_INIT_W1      = 3'd2;
  localparam logic [2:0] REG_INIT_W2      = 3'd3;
  localparam logic [2:0] REG_INIT_W3      = 3'd4;
  localparam logic [2:0] REG_ADAPT_PERIOD = 3'd5;
  localparam logic [2:0] REG_ADAPT_FACTOR = 3'd6;

  // Register reset values.
  localparam logic [2:0]  OPS_RST    = 3'd4;
  localparam logic [15:0] INIT_W_RST = 16'd1;
  localparam logic [15:0] PERIOD_RST = 16'd20;
  localparam logic [15:0] FACTOR_RST = 16'd58982;

endpackage
`default_nettype wire

/* sv/adaptive_operator_roulette_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_operator_roulette_top
// Roulette-wheel operator selection with success-driven weight adaptation.
// ----------------------------------------------------------------------------
// Sequence: a select item scans the wheel before its result; the first select
// before that loads the initial weights and normalizes them, one division per
// operator. An outcome item updates the counts and, when it adapts, compares
// the success ratios, scales the weights by the factor and renormalizes them.
// Throughput: one item at a time; in_tready is high only in idle, and a result
// the receiver has not taken holds the block in its last step.
// Reset (synchronous, rst_n low) clears counts, state and registers to their
// defaults; weights are undefined until the first select loads them.
module adaptive_operator_roulette_top #(
  parameter int MAX_OPS          = aor_pkg::MAX_OPS_DEF,
  parameter int WEIGHT_FRAC_BITS = aor_pkg::WEIGHT_FRAC_DEF,
  parameter int COUNT_BITS       = aor_pkg::COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] random_draw, [16] improved
  input  wire logic        in_tuser,   // [0] op
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [1:0] chosen_operator, [2] adapted,
                                       // [4:3] partner_operator
  // Configuration port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  localparam int F   = WEIGHT_FRAC_BITS;
  localparam int C   = COUNT_BITS;
  localparam int IW  = $clog2(MAX_OPS);
  localparam int WB  = F + 2;                      // normalized weight width
  localparam int RW  = (WB > 16) ? WB : 16;        // raw weight storage width
  localparam int SW  = RW + 2;                     // sum of all weights
  localparam int DW  = SW;                         // divisor width
  localparam int NW  = ((RW + F) > (WB + 16)) ? (RW + F) : (WB + 16);
  localparam int XW  = F + 18;                     // scan accumulator width
  localparam int MA  = (C > RW) ? C : RW;
  localparam int MB  = (C > 16) ? C : 16;
  localparam int PW  = MA + MB;
  localparam int PC  = (C > 16) ? C : 16;
  localparam logic [WB-1:0] WMAX = '1;
  localparam logic [C-1:0]  CMAX = '1;
  localparam int unsigned SH1 = (2 ** F) / 1;
  localparam int unsigned SH2 = (2 ** F) / 2;
  localparam int unsigned SH3 = (2 ** F) / 3;
  localparam int unsigned SH4 = (2 ** F) / 4;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RN_SUM, S_RN_DIV, S_RN_WAIT, S_SCAN, S_UPD, S_PART,
    S_MUL1, S_MUL2, S_DEC, S_SC, S_SC_WAIT, S_DONE
  } state_t;

  typedef enum logic [1:0] {ACT_NONE, ACT_MUL, ACT_DIV} act_t;

  // Configuration registers.
  logic [2:0]  ops_r;
  logic [15:0] initw_r [4];
  logic [15:0] period_r;
  logic [15:0] factor_r;

  // Block state.
  state_t        state_r;
  logic          ready_r;
  logic [RW-1:0] w_r    [MAX_OPS];
  logic [C-1:0]  succ_r [MAX_OPS];
  logic [C-1:0]  use_r  [MAX_OPS];
  logic [IW-1:0] last_r;

  // Working registers for the item in progress.
  logic          op_r;
  logic [15:0]   draw_r;
  logic          imp_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] o_r;
  logic          k_r;
  logic [SW-1:0] sum_r;
  logic [XW-1:0] acc_r;
  logic [PW-1:0] lt_r;
  logic [PW-1:0] lo_r;
  logic [RW-1:0] wt_r;
  act_t          act_t_r;
  act_t          act_o_r;
  logic [1:0]    res_ch_r;
  logic          res_ad_r;
  logic [1:0]    res_pa_r;
  logic          out_valid_r;
  logic [7:0]    out_data_r;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ops_r      <= aor_pkg::OPS_RST;
      initw_r[0] <= aor_pkg::INIT_W_RST;
      initw_r[1] <= aor_pkg::INIT_W_RST;
      initw_r[2] <= aor_pkg::INIT_W_RST;
      initw_r[3] <= aor_pkg::INIT_W_RST;
      period_r   <= aor_pkg::PERIOD_RST;
      factor_r   <= aor_pkg::FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        aor_pkg::REG_OPS_IN_USE:   ops_r      <= cfg_wdata[2:0];
        aor_pkg::REG_INIT_W0:      initw_r[0] <= cfg_wdata;
        aor_pkg::REG_INIT_W1:      initw_r[1] <= cfg_wdata;
        aor_pkg::REG_INIT_W2:      initw_r[2] <= cfg_wdata;
        aor_pkg::REG_INIT_W3:      initw_r[3] <= cfg_wdata;
        aor_pkg::REG_ADAPT_PERIOD: period_r   <= cfg_wdata;
        aor_pkg::REG_ADAPT_FACTOR: factor_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective operator count, period and factor: zero and overlarge
  // settings are folded into the legal range.
  logic [2:0]  n_w;
  logic [15:0] period_w;
  logic [15:0] f_w;

  always_comb begin
    if (ops_r == 3'd0) begin
      n_w = 3'd1;
    end else if (ops_r > 3'(MAX_OPS)) begin
      n_w = 3'(MAX_OPS);
    end else begin
      n_w = ops_r;
    end
  end

  assign period_w = (period_r == 16'd0) ? 16'd1 : period_r;
  assign f_w      = (factor_r == 16'd0) ? 16'd1 : factor_r;

  logic [RW-1:0] share_w;

  always_comb begin
    case (n_w)
      3'd1:    share_w = RW'(SH1);
      3'd2:    share_w = RW'(SH2);
      3'd3:    share_w = RW'(SH3);
      default: share_w = RW'(SH4);
    endcase
  end

  // The operator currently charged and the one being scaled.
  logic [IW-1:0] t_w;
  logic [IW-1:0] cur_w;
  act_t          act_w;

  assign t_w   = last_r;
  assign cur_w = k_r ? o_r : t_w;
  assign act_w = k_r ? act_o_r : act_t_r;

  // Single read port on the weight file, steered by the sequencer.
  logic [IW-1:0] w_idx;
  logic [RW-1:0] w_rd;

  always_comb begin
    case (state_r)
      S_MUL1:            w_idx = t_w;
      S_DEC:             w_idx = o_r;
      S_SC, S_SC_WAIT:   w_idx = cur_w;
      default:           w_idx = idx_r;
    endcase
  end

  assign w_rd = w_r[w_idx];

  // Count read ports for the cross-multiplication.
  logic [IW-1:0] cs_idx;
  logic [IW-1:0] cu_idx;
  logic [C-1:0]  succ_rd;
  logic [C-1:0]  use_rd;

  assign cs_idx  = (state_r == S_MUL1) ? t_w : o_r;
  assign cu_idx  = (state_r == S_MUL1) ? o_r : t_w;
  assign succ_rd = succ_r[cs_idx];
  assign use_rd  = use_r[cu_idx];

  // Shared multiplier: success ratios while comparing, weight times factor
  // while scaling.
  logic [MA-1:0] mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] prod_w;
  logic          cmp_phase;

  assign cmp_phase = (state_r == S_MUL1) || (state_r == S_MUL2);
  assign mul_a     = cmp_phase ? MA'(succ_rd) : MA'(w_rd);
  assign mul_b     = cmp_phase ? MB'(use_rd) : MB'(f_w);
  assign prod_w    = PW'(mul_a) * PW'(mul_b);

  // Shared divider.
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [WB-1:0] quo_sat;

  assign div_start = (state_r == S_RN_DIV) || ((state_r == S_SC) && (act_w == ACT_DIV));
  assign div_num   = (state_r == S_RN_DIV) ? (NW'(w_rd) << F) : (NW'(w_rd) << 16);
  assign div_den   = (state_r == S_RN_DIV) ? sum_r : DW'(f_w);
  assign quo_sat   = (div_quo > NW'(WMAX)) ? WMAX : div_quo[WB-1:0];

  aor_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Sum of all weights for normalization.
  logic [SW-1:0] sum_w;

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < MAX_OPS; i++) begin
      sum_w = sum_w + SW'(w_r[i]);
    end
  end

  // Draw moved from Q0.16 to F fraction bits, and the scan step.
  logic [F+15:0] dfull;
  logic [XW-1:0] acc_nxt;
  logic          hit;
  logic          last_op;

  assign dfull   = {draw_r, {F{1'b0}}};
  assign acc_nxt = acc_r + XW'(w_rd);
  assign hit     = XW'(dfull[F+15:16]) <= acc_nxt;
  assign last_op = (3'(idx_r) == (n_w - 3'd1));

  // Partner search: lowest operator in use, other than the charged one,
  // that has reached the period.
  logic          part_found;
  logic [IW-1:0] part_idx;

  always_comb begin
    part_found = 1'b0;
    part_idx   = '0;
    for (int i = MAX_OPS - 1; i >= 0; i--) begin
      if ((i < int'(n_w)) && (IW'(i) != t_w) &&
          (PC'(use_r[i]) >= PC'(period_w))) begin
        part_found = 1'b1;
        part_idx   = IW'(i);
      end
    end
  end

  logic t_ready_w;
  assign t_ready_w = PC'(use_r[t_w]) >= PC'(period_w);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_OPS; i++) begin
        succ_r[i] <= '0;
        use_r[i]  <= '0;
      end
    end else begin
      // The done step sets the valid flag itself when it loads a new result.
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r     <= in_tuser;
            draw_r   <= in_tdata[15:0];
            imp_r    <= in_tdata[16];
            idx_r    <= '0;
            acc_r    <= '0;
            res_ch_r <= 2'(last_r);
            res_ad_r <= 1'b0;
            res_pa_r <= 2'd0;
            if (!in_tuser) begin
              state_r <= ready_r ? S_SCAN : S_LOAD;
            end else begin
              // An outcome before any select changes nothing.
              state_r <= ready_r ? S_UPD : S_DONE;
            end
          end
        end

        S_LOAD: begin
          for (int i = 0; i < MAX_OPS; i++) begin
            w_r[i]    <= (i < int'(n_w)) ? RW'(initw_r[i % 4]) : '0;
            succ_r[i] <= '0;
            use_r[i]  <= '0;
          end
          ready_r <= 1'b1;
          state_r <= S_RN_SUM;
        end

        S_RN_SUM: begin
          idx_r <= '0;
          sum_r <= sum_w;
          if (sum_w == '0) begin
            // Every weight zero: equal shares among operators in use.
            for (int i = 0; i < MAX_OPS; i++) begin
              w_r[i] <= (i < int'(n_w)) ? share_w : '0;
            end
            acc_r   <= '0;
            state_r <= op_r ? S_DONE : S_SCAN;
          end else begin
            state_r <= S_RN_DIV;
          end
        end

        S_RN_DIV: begin
          state_r <= S_RN_WAIT;
        end

        S_RN_WAIT: begin
          if (div_done) begin
            w_r[idx_r] <= div_quo[RW-1:0];
            if (idx_r == IW'(MAX_OPS - 1)) begin
              idx_r   <= '0;
              acc_r   <= '0;
              state_r <= op_r ? S_DONE : S_SCAN;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RN_DIV;
            end
          end
        end

        S_SCAN: begin
          acc_r <= acc_nxt;
          // The last operator in use takes the draw if the sums fall short.
          if (hit || last_op) begin
            last_r   <= idx_r;
            res_ch_r <= 2'(idx_r);
            state_r  <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end

        S_UPD: begin
          if (use_r[t_w] != CMAX) begin
            use_r[t_w] <= use_r[t_w] + 1'b1;
          end
          if (imp_r && (succ_r[t_w] != CMAX)) begin
            succ_r[t_w] <= succ_r[t_w] + 1'b1;
          end
          state_r <= S_PART;
        end

        S_PART: begin
          if (t_ready_w && part_found) begin
            o_r     <= part_idx;
            state_r <= S_MUL1;
          end else begin
            state_r <= S_DONE;
          end
        end

        S_MUL1: begin
          lt_r    <= prod_w;
          wt_r    <= w_rd;
          state_r <= S_MUL2;
        end

        S_MUL2: begin
          lo_r    <= prod_w;
          state_r <= S_DEC;
        end

        S_DEC: begin
          // The better ratio is divided by the factor, the worse multiplied;
          // on a tie in ratio only the larger weight shrinks.
          if (lt_r > lo_r) begin
            act_t_r <= ACT_DIV;
            act_o_r <= ACT_MUL;
          end else if (lt_r < lo_r) begin
            act_t_r <= ACT_MUL;
            act_o_r <= ACT_DIV;
          end else if (wt_r > w_rd) begin
            act_t_r <= ACT_MUL;
            act_o_r <= ACT_NONE;
          end else if (wt_r < w_rd) begin
            act_t_r <= ACT_NONE;
            act_o_r <= ACT_MUL;
          end else begin
            act_t_r <= ACT_NONE;
            act_o_r <= ACT_NONE;
          end
          k_r     <= 1'b0;
          state_r <= S_SC;
        end

        S_SC: begin
          case (act_w)
            ACT_DIV: state_r <= S_SC_WAIT;
            ACT_MUL: begin
              w_r[cur_w] <= prod_w[16 +: RW];
            end
            default: ;
          endcase
          if (act_w != ACT_DIV) begin
            if (k_r) begin
              succ_r[t_w] <= '0;
              succ_r[o_r] <= '0;
              use_r[t_w]  <= '0;
              use_r[o_r]  <= '0;
              res_ad_r    <= 1'b1;
              res_pa_r    <= 2'(o_r);
              state_r     <= S_RN_SUM;
            end else begin
              k_r <= 1'b1;
            end
          end
        end

        S_SC_WAIT: begin
          if (div_done) begin
            w_r[cur_w] <= RW'(quo_sat);
            if (k_r) begin
              succ_r[t_w] <= '0;
              succ_r[o_r] <= '0;
              use_r[t_w]  <= '0;
              use_r[o_r]  <= '0;
              res_ad_r    <= 1'b1;
              res_pa_r    <= 2'(o_r);
              state_r     <= S_RN_SUM;
            end else begin
              k_r     <= 1'b1;
              state_r <= S_SC;
            end
          end
        end

        S_DONE: begin
          // Hand the result to the output register once it is free.
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {3'b000, res_pa_r, res_ad_r, res_ch_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/aor_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// aor_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// weight normalization and the factor division.
// ----------------------------------------------------------------------------
module aor_div #(
  parameter int NW = 42,
  parameter int DW = 20
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [NW-1:0] q_r;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;

  assign shifted = {rem_r, q_r[NW-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign done    = done_r;
  assign quo     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        rem_r  <= '0;
        q_r    <= num;
        den_r  <= den;
      end else if (busy_r) begin
        // A set top bit means the trial subtraction went negative.
        if (!trial[DW]) begin
          rem_r <= trial[DW-1:0];
        end else begin
          rem_r <= shifted[DW-1:0];
        end
        q_r   <= {q_r[NW-2:0], ~trial[DW]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the adaptive operator roulette. Select and outcome
// transfers are driven with random gaps and checked against a behavioral
// model of the weight table, the use and success counts and the pairwise
// adaptation, across several register settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic OP_SELECT  = 1'b0;
  localparam logic OP_OUTCOME = 1'b1;
  localparam int   NOPS       = 4;
  localparam longint W_ONE    = 64'd65536;
  localparam longint W_MAX    = (64'd1 << 18) - 1;
  localparam longint C_MAX    = 64'd65535;
  localparam int   IDLE_LIMIT = 20000;

  // Packed from the highest bit down, so chosen sits in the lowest bits.
  typedef struct packed {
    logic [1:0] partner;
    logic       adapted;
    logic [1:0] chosen;
  } choice_t;

  // Scoreboard: holds the roulette state and the queue of pending choices.
  class roulette_sb;
    logic [2:0]  ops_reg;
    logic [15:0] init_w[NOPS];
    logic [15:0] period_reg, factor_reg;
    bit          loaded;
    longint      weight[NOPS], wins[NOPS], uses[NOPS];
    logic [1:0]  last_pick;
    choice_t     pending[$];
    int          errors;

    function void clear();
      ops_reg = aor_pkg::OPS_RST;
      period_reg = aor_pkg::PERIOD_RST;
      factor_reg = aor_pkg::FACTOR_RST;
      for (int i = 0; i < NOPS; i++) begin
        init_w[i] = aor_pkg::INIT_W_RST; weight[i] = 0; wins[i] = 0; uses[i] = 0;
      end
      loaded = 0; last_pick = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        aor_pkg::REG_OPS_IN_USE:   ops_reg = val[2:0];
        aor_pkg::REG_INIT_W0:      init_w[0] = val;
        aor_pkg::REG_INIT_W1:      init_w[1] = val;
        aor_pkg::REG_INIT_W2:      init_w[2] = val;
        aor_pkg::REG_INIT_W3:      init_w[3] = val;
        aor_pkg::REG_ADAPT_PERIOD: period_reg = val;
        aor_pkg::REG_ADAPT_FACTOR: factor_reg = val;
        default: ;
      endcase
    endfunction

    function int active();
      if (ops_reg == 0) return 1;
      if (ops_reg > NOPS) return NOPS;
      return int'(ops_reg);
    endfunction

    function void rebalance(int n);
      longint total;
      total = 0;
      for (int i = 0; i < NOPS; i++) total += weight[i];
      for (int i = 0; i < NOPS; i++)
        if (total == 0) weight[i] = (i < n) ? W_ONE / n : 0;
        else weight[i] = (weight[i] << 16) / total;
    endfunction

    function longint shrink(longint w, longint f);
      return (w * f) >> 16;
    endfunction

    function longint grow(longint w, longint f);
      longint q;
      q = (w << 16) / f;
      return (q > W_MAX) ? W_MAX : q;
    endfunction

    // Works out the result of one accepted input transfer.
    function void note_input(logic op, logic [15:0] draw, logic improved);
      int n, t, o;
      longint acc, per, f, lt, lo;
      choice_t c;
      n = active(); c = '0;
      if (op == OP_SELECT) begin
        if (!loaded) begin
          for (int i = 0; i < NOPS; i++) begin
            weight[i] = (i < n) ? init_w[i] : 0; wins[i] = 0; uses[i] = 0;
          end
          rebalance(n);
          loaded = 1;
        end
        acc = 0; t = n - 1;
        for (int i = 0; i < n; i++) begin
          acc += weight[i];
          if (draw <= acc) begin t = i; break; end
        end
        last_pick = 2'(t);
      end else if (loaded) begin
        t = last_pick;
        per = period_reg ? period_reg : 1;
        f = factor_reg ? factor_reg : 1;
        if (uses[t] < C_MAX) uses[t]++;
        if (improved && wins[t] < C_MAX) wins[t]++;
        if (uses[t] >= per) begin
          for (o = 0; o < n; o++) if (o != t && uses[o] >= per) break;
          if (o < n) begin
            lt = wins[t] * uses[o];
            lo = wins[o] * uses[t];
            if (lt > lo) begin
              weight[t] = grow(weight[t], f); weight[o] = shrink(weight[o], f);
            end else if (lt < lo) begin
              weight[t] = shrink(weight[t], f); weight[o] = grow(weight[o], f);
            end else if (weight[t] > weight[o]) begin
              weight[t] = shrink(weight[t], f);
            end else if (weight[t] < weight[o]) begin
              weight[o] = shrink(weight[o], f);
            end
            wins[t] = 0; wins[o] = 0; uses[t] = 0; uses[o] = 0;
            rebalance(n);
            c.adapted = 1; c.partner = 2'(o);
          end
        end
      end
      c.chosen = last_pick;
      pending = {pending, c};
    endfunction

    function void check_result(logic [7:0] data);
      choice_t exp_c, got;
      got = data[4:0];
      if (pending.size() == 0) begin
        $error("unexpected result transfer %h", data);
        errors++;
        return;
      end
      exp_c = pending.pop_front();
      if (got.chosen !== exp_c.chosen) begin
        $error("chosen_operator: expected %0d, actual %0d", exp_c.chosen, got.chosen);
        errors++;
      end
      if (got.adapted !== exp_c.adapted) begin
        $error("adapted: expected %0d, actual %0d", exp_c.adapted, got.adapted);
        errors++;
      end
      if (got.partner !== exp_c.partner) begin
        $error("partner_operator: expected %0d, actual %0d", exp_c.partner, got.partner);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_tvalid, in_tready, in_tuser;
  logic [23:0] in_tdata;
  logic        out_tvalid, out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  roulette_sb sb;
  bit  stall_on = 1;   // random gaps enabled on both sides
  int  idle_cycles = 0;
  bit  timed_out = 0;

  adaptive_operator_roulette_top uut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    sb.clear();
  end

  // The receiver drops out_tready in random bursts while gaps are on.
  initial begin
    int gap;
    out_tready = 0;
    forever begin
      @(posedge clk);
      if (gap > 0) begin
        gap--;
        out_tready <= 0;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(0, 6);
        out_tready <= 0;
      end else begin
        out_tready <= 1;
      end
    end
  end

  // Results are checked at the edge where the transfer completes.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("FAILURE");
      $finish;
    end
  end

  // Write enable is dropped by the caller after the last write of a set.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Drives one item and waits for the transfer; a random gap may come first.
  // Valid stays high after the transfer until the next item or a drain.
  task automatic send_item(logic op, logic [15:0] draw, logic improved);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, improved, draw};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, draw, improved);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Mostly select/outcome pairs, as the block is used; some bare items too.
  task automatic random_items(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8) begin
        send_item(OP_SELECT, 16'($urandom), 1'($urandom));
        send_item(OP_OUTCOME, 16'($urandom), $urandom_range(0, 3) != 0);
      end else begin
        send_item(1'($urandom), 16'($urandom), 1'($urandom));
      end
    end
  endtask

  // Loads a full register set; a fresh reset-free reload comes from the
  // first select of the phase only when nothing has been selected yet, so
  // later phases run with the adapted weights and the new period and factor.
  task automatic setup(logic [2:0] ops, logic [15:0] w0, logic [15:0] w1,
                       logic [15:0] w2, logic [15:0] w3, logic [15:0] per,
                       logic [15:0] fac);
    write_reg(aor_pkg::REG_OPS_IN_USE, ops);
    write_reg(aor_pkg::REG_INIT_W0, w0);
    write_reg(aor_pkg::REG_INIT_W1, w1);
    write_reg(aor_pkg::REG_INIT_W2, w2);
    write_reg(aor_pkg::REG_INIT_W3, w3);
    write_reg(aor_pkg::REG_ADAPT_PERIOD, per);
    write_reg(aor_pkg::REG_ADAPT_FACTOR, fac);
    cfg_we <= 0;
  endtask

  initial begin
    rst_n = 0; in_tvalid = 0; in_tuser = 0; in_tdata = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: outcomes before any select are ignored, then an all-zero
    // load gives equal shares, and draw extremes probe the wheel ends.
    send_item(OP_OUTCOME, 16'hFFFF, 1'b1);
    send_item(OP_OUTCOME, 16'h0000, 1'b0);
    drain();
    setup(3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(OP_SELECT, 16'h0000, 1'b0);
    send_item(OP_SELECT, 16'hFFFF, 1'b1);
    send_item(OP_OUTCOME, 16'h8000, 1'b1);
    send_item(OP_SELECT, 16'h4000, 1'b0);
    send_item(OP_OUTCOME, 16'h0001, 1'b0);
    send_item(OP_SELECT, 16'hC000, 1'b0);
    send_item(OP_OUTCOME, 16'h7FFF, 1'b1);
    send_item(OP_SELECT, 16'h3FFF, 1'b1);
    send_item(OP_OUTCOME, 16'h0000, 1'b0);
    send_item(OP_SELECT, 16'h4001, 1'b0);
    send_item(OP_OUTCOME, 16'hFFFF, 1'b1);
    send_item(OP_SELECT, 16'hBFFF, 1'b0);
    send_item(OP_OUTCOME, 16'h5555, 1'b0);
    send_item(OP_SELECT, 16'hAAAA, 1'b1);
    send_item(OP_OUTCOME, 16'h0F0F, 1'b1);
    drain();

    // Weights from the first load persist, so each reset-free phase below
    // mainly varies count, period and factor; the heavy-weight phase uses ops 0.
    setup(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1);
    random_items(120);
    drain();
    setup(3'd2, 16'h0001, 16'hFFFF, 16'd0, 16'd0, 16'd3, 16'hFFFF);
    random_items(200);
    drain();
    setup(3'd4, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 16'd32768);
    random_items(250);
    drain();
    setup(3'd3, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'd5,
          aor_pkg::FACTOR_RST);
    random_items(150);
    drain();
    setup(3'd4, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'hFFFF,
          16'd1000);
    random_items(30);
    drain();

    // Final stretch without gaps on either side.
    setup(3'd4, 16'd1, 16'd1, 16'd1, 16'd1, 16'd4, aor_pkg::FACTOR_RST);
    stall_on = 0;
    random_items(100);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
